[rtl/slot_pool_alive_dead_stacks_macros.svh]
// Assertion macros for the slot pool checker.
// No dependencies; included by the checker file.
`ifndef SLOT_POOL_ALIVE_DEAD_STACKS_MACROS_SVH
`define SLOT_POOL_ALIVE_DEAD_STACKS_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SPADS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SPADS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spads_pkg.sv]
// Shared constants and types for the slot pool allocator.
// No dependencies; used by the top level and the checker.
package spads_pkg;

  localparam int unsigned POOL_SIZE = 256;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned POS_W     = 8;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [CNT_W-1:0] top_t;
  typedef logic [STAT_W-1:0]       stat_t;

  localparam logic [FUNC_W-1:0] FN_INIT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_KILL  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_BIRTH = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TIDY  = 2'd3;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_EMPTY  = 2'd1;
  localparam stat_t ST_NOFREE = 2'd2;

endpackage

[rtl/slot_pool_alive_dead_stacks.sv]
// Slot pool allocator: alive list with holes plus a free-id stack.
// Microcoded control; depends on spads_pkg.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, initial_alive_i): sets the count of
//   ids that init makes alive; always ready, write it only while idle.
//   in channel (in_valid_i/in_ready_o, func_i, position_i): one operation per
//   transfer: init, kill at position, birth, tidy.
//   out channel (out_valid_o/out_ready_i): one result per operation with
//   status_o, slot_id_o and top_index_o.
// Steps from input transfer to result valid, set by the step program:
//   kill, birth: a jump step, a check step that reads memory, then, unless flagged, a write step.
//   init: one alive/free memory write per position.
//   tidy: a scan over the list plus two steps per moved entry (read, then write).
// One operation is in flight at a time; the next input is taken once the
// result sits in the output register, even while that result is stalled.
// A stalled receiver holds the result, and the sequencer waits in its
// result step if a second result is ready before the first is taken.
// Reset: alive list empty, free stack empty, both tops at -1, count 0.
module slot_pool_alive_dead_stacks (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [spads_pkg::CNT_W-1:0]          initial_alive_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [spads_pkg::FUNC_W-1:0]         func_i,
  input  logic [spads_pkg::POS_W-1:0]          position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [spads_pkg::STAT_W-1:0]         status_o,
  output logic [spads_pkg::ID_W-1:0]           slot_id_o,
  output logic signed [spads_pkg::CNT_W-1:0]   top_index_o
);
  import spads_pkg::*;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    A_NOP, A_ACCEPT, A_INIT_SET, A_INIT_FILL, A_INIT_END, A_KILL_CHK, A_KILL_DO,
    A_BIRTH_CHK, A_BIRTH_DO, A_TIDY_SET, A_TIDY_SCAN, A_TIDY_END, A_RESP
  } act_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_DISPATCH, C_K_LAST, C_KILL_BAD, C_BIRTH_BAD, C_TIDY_END, C_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  tgt;
    upc_t  alt;
  } uword_t;

  localparam upc_t U_IDLE      = 4'd0;
  localparam upc_t U_JMP_INIT  = 4'd1;
  localparam upc_t U_JMP_KILL  = 4'd2;
  localparam upc_t U_JMP_BIRTH = 4'd3;
  localparam upc_t U_JMP_TIDY  = 4'd4;
  localparam upc_t U_INIT_SET  = 4'd5;
  localparam upc_t U_INIT_FILL = 4'd6;
  localparam upc_t U_INIT_END  = 4'd7;
  localparam upc_t U_KILL_CHK  = 4'd8;
  localparam upc_t U_KILL_DO   = 4'd9;
  localparam upc_t U_BIRTH_CHK = 4'd10;
  localparam upc_t U_BIRTH_DO  = 4'd11;
  localparam upc_t U_TIDY_SET  = 4'd12;
  localparam upc_t U_TIDY_SCAN = 4'd13;
  localparam upc_t U_TIDY_END  = 4'd14;
  localparam upc_t U_RESP      = 4'd15;

  // step program: taken condition jumps to tgt (plus func_i on dispatch), else to alt
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      U_IDLE:      w = '{A_ACCEPT,    C_DISPATCH,  U_JMP_INIT,  U_IDLE};
      U_JMP_INIT:  w = '{A_NOP,       C_ALWAYS,    U_INIT_SET,  U_INIT_SET};
      U_JMP_KILL:  w = '{A_NOP,       C_ALWAYS,    U_KILL_CHK,  U_KILL_CHK};
      U_JMP_BIRTH: w = '{A_NOP,       C_ALWAYS,    U_BIRTH_CHK, U_BIRTH_CHK};
      U_JMP_TIDY:  w = '{A_NOP,       C_ALWAYS,    U_TIDY_SET,  U_TIDY_SET};
      U_INIT_SET:  w = '{A_INIT_SET,  C_ALWAYS,    U_INIT_FILL, U_INIT_FILL};
      U_INIT_FILL: w = '{A_INIT_FILL, C_K_LAST,    U_INIT_END,  U_INIT_FILL};
      U_INIT_END:  w = '{A_INIT_END,  C_ALWAYS,    U_RESP,      U_RESP};
      U_KILL_CHK:  w = '{A_KILL_CHK,  C_KILL_BAD,  U_RESP,      U_KILL_DO};
      U_KILL_DO:   w = '{A_KILL_DO,   C_ALWAYS,    U_RESP,      U_RESP};
      U_BIRTH_CHK: w = '{A_BIRTH_CHK, C_BIRTH_BAD, U_RESP,      U_BIRTH_DO};
      U_BIRTH_DO:  w = '{A_BIRTH_DO,  C_ALWAYS,    U_RESP,      U_RESP};
      U_TIDY_SET:  w = '{A_TIDY_SET,  C_ALWAYS,    U_TIDY_SCAN, U_TIDY_SCAN};
      U_TIDY_SCAN: w = '{A_TIDY_SCAN, C_TIDY_END,  U_TIDY_END,  U_TIDY_SCAN};
      U_TIDY_END:  w = '{A_TIDY_END,  C_ALWAYS,    U_RESP,      U_RESP};
      U_RESP:      w = '{A_RESP,      C_OUT_FREE,  U_IDLE,      U_RESP};
      default:     w = '{A_NOP,       C_ALWAYS,    U_IDLE,      U_IDLE};
    endcase
    return w;
  endfunction

  // control state
  upc_t                 upc_q, upc_d;
  logic                 out_valid_q, out_valid_d;
  logic [POOL_SIZE-1:0] valid_q, valid_d;
  top_t                 alive_top_q, alive_top_d;
  top_t                 free_top_q, free_top_d;
  cnt_t                 count_q, count_d;
  cnt_t                 init_alive_q, init_alive_d;
  logic                 mv_q, mv_d;

  // datapath registers
  idx_t                 pos_q, pos_d;
  cnt_t                 n_q, n_d;
  idx_t                 k_q, k_d;
  idx_t                 lo_q, lo_d;
  idx_t                 hi_q, hi_d;
  stat_t                stat_q, stat_d;
  idx_t                 id_q, id_d;
  stat_t                out_stat_q, out_stat_d;
  idx_t                 out_id_q, out_id_d;
  top_t                 out_top_q, out_top_d;

  // memories
  idx_t alive_mem [POOL_SIZE];
  idx_t free_mem  [POOL_SIZE];
  idx_t alive_rd_q, free_rd_q;
  logic am_we, am_re, fm_we, fm_re;
  idx_t am_waddr, am_wdata, am_raddr, fm_waddr, fm_wdata, fm_raddr;

  uword_t uw;
  logic   taken;
  logic   kill_bad, birth_bad, scan_live, tidy_end, out_free;
  top_t   alive_next, free_next;
  cnt_t   n_sat;

  assign uw         = ucode(upc_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign kill_bad   = !valid_q[pos_q];
  assign birth_bad  = free_top_q[CNT_W-1] || (alive_top_q == top_t'(POOL_SIZE - 1));
  assign scan_live  = lo_q < hi_q;
  assign tidy_end   = !mv_q && !scan_live;
  assign alive_next = alive_top_q + top_t'(1);
  assign free_next  = free_top_q + top_t'(1);
  assign n_sat      = (init_alive_q > cnt_t'(POOL_SIZE)) ? cnt_t'(POOL_SIZE) : init_alive_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (uw.act == A_ACCEPT);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign slot_id_o   = ID_W'(out_id_q);
  assign top_index_o = out_top_q;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_DISPATCH:  taken = in_valid_i;
      C_K_LAST:    taken = (k_q == idx_t'(POOL_SIZE - 1));
      C_KILL_BAD:  taken = kill_bad;
      C_BIRTH_BAD: taken = birth_bad;
      C_TIDY_END:  taken = tidy_end;
      C_OUT_FREE:  taken = out_free;
      default:     taken = 1'b1;
    endcase
    if (!taken) begin
      upc_d = uw.alt;
    end else if (uw.cond == C_DISPATCH) begin
      upc_d = uw.tgt + upc_t'(func_i);
    end else begin
      upc_d = uw.tgt;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    valid_d      = valid_q;
    alive_top_d  = alive_top_q;
    free_top_d   = free_top_q;
    count_d      = count_q;
    init_alive_d = init_alive_q;
    mv_d         = mv_q;
    pos_d        = pos_q;
    n_d          = n_q;
    k_d          = k_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    stat_d       = stat_q;
    id_d         = id_q;
    out_stat_d   = out_stat_q;
    out_id_d     = out_id_q;
    out_top_d    = out_top_q;
    am_we        = 1'b0;
    am_waddr     = k_q;
    am_wdata     = k_q;
    am_re        = 1'b0;
    am_raddr     = pos_q;
    fm_we        = 1'b0;
    fm_waddr     = k_q;
    fm_wdata     = idx_t'(POOL_SIZE - 1) - k_q;
    fm_re        = 1'b0;
    fm_raddr     = free_top_q[IDX_W-1:0];

    if (cfg_valid_i) begin
      init_alive_d = initial_alive_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (uw.act)
      A_ACCEPT: begin
        pos_d = idx_t'(position_i);
      end
      A_INIT_SET: begin
        n_d    = n_sat;
        k_d    = '0;
        stat_d = ST_OK;
        id_d   = '0;
      end
      A_INIT_FILL: begin
        am_we      = 1'b1;
        fm_we      = 1'b1;
        valid_d[k_q] = ({1'b0, k_q} < n_q);
        k_d        = k_q + idx_t'(1);
      end
      A_INIT_END: begin
        alive_top_d = top_t'(n_q - cnt_t'(1));
        free_top_d  = top_t'(cnt_t'(POOL_SIZE - 1) - n_q);
        count_d     = n_q;
      end
      A_KILL_CHK: begin
        am_re  = 1'b1;
        stat_d = kill_bad ? ST_EMPTY : ST_OK;
        id_d   = '0;
      end
      A_KILL_DO: begin
        id_d           = alive_rd_q;
        valid_d[pos_q] = 1'b0;
        free_top_d     = free_next;
        fm_we          = 1'b1;
        fm_waddr       = free_next[IDX_W-1:0];
        fm_wdata       = alive_rd_q;
        count_d        = count_q - cnt_t'(1);
      end
      A_BIRTH_CHK: begin
        fm_re  = 1'b1;
        stat_d = birth_bad ? ST_NOFREE : ST_OK;
        id_d   = '0;
      end
      A_BIRTH_DO: begin
        id_d        = free_rd_q;
        free_top_d  = free_top_q - top_t'(1);
        alive_top_d = alive_next;
        am_we       = 1'b1;
        am_waddr    = alive_next[IDX_W-1:0];
        am_wdata    = free_rd_q;
        valid_d[alive_next[IDX_W-1:0]] = 1'b1;
        count_d     = count_q + cnt_t'(1);
      end
      A_TIDY_SET: begin
        lo_d   = '0;
        hi_d   = idx_t'(POOL_SIZE - 1);
        mv_d   = 1'b0;
        stat_d = ST_OK;
        id_d   = '0;
      end
      A_TIDY_SCAN: begin
        if (mv_q) begin
          // last occupied entry lands in the first hole
          am_we         = 1'b1;
          am_waddr      = lo_q;
          am_wdata      = alive_rd_q;
          valid_d[lo_q] = 1'b1;
          valid_d[hi_q] = 1'b0;
          mv_d          = 1'b0;
        end else if (scan_live) begin
          if (valid_q[lo_q]) begin
            lo_d = lo_q + idx_t'(1);
          end else if (!valid_q[hi_q]) begin
            hi_d = hi_q - idx_t'(1);
          end else begin
            am_re    = 1'b1;
            am_raddr = hi_q;
            mv_d     = 1'b1;
          end
        end
      end
      A_TIDY_END: begin
        alive_top_d = top_t'(count_q - cnt_t'(1));
      end
      A_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_id_d    = id_q;
          out_top_d   = alive_top_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= U_IDLE;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      alive_top_q  <= top_t'(-1);
      free_top_q   <= top_t'(-1);
      count_q      <= '0;
      init_alive_q <= '0;
      mv_q         <= 1'b0;
    end else begin
      upc_q        <= upc_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
      alive_top_q  <= alive_top_d;
      free_top_q   <= free_top_d;
      count_q      <= count_d;
      init_alive_q <= init_alive_d;
      mv_q         <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    n_q        <= n_d;
    k_q        <= k_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    stat_q     <= stat_d;
    id_q       <= id_d;
    out_stat_q <= out_stat_d;
    out_id_q   <= out_id_d;
    out_top_q  <= out_top_d;
  end

  always_ff @(posedge clk_i) begin
    if (am_we) begin
      alive_mem[am_waddr] <= am_wdata;
    end
    if (am_re) begin
      alive_rd_q <= alive_mem[am_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      free_mem[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      free_rd_q <= free_mem[fm_raddr];
    end
  end

endmodule

[rtl/spads_checker.sv]
// Port-level checks for the slot pool allocator, bound to the top level.
// Depends on spads_pkg and slot_pool_alive_dead_stacks_macros.svh.
`include "slot_pool_alive_dead_stacks_macros.svh"

module spads_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic [spads_pkg::STAT_W-1:0]       status_o,
  input  logic [spads_pkg::ID_W-1:0]         slot_id_o,
  input  logic signed [spads_pkg::CNT_W-1:0] top_index_o
);
  import spads_pkg::*;

  `SPADS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(slot_id_o) && $stable(top_index_o), "result changed while stalled")
  `SPADS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second transfer taken while busy")
  `SPADS_ASSERT_NOW(a_status_code, out_valid_o, status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_NOFREE, "bad status code")
  `SPADS_ASSERT_NOW(a_flag_no_id, out_valid_o && status_o != ST_OK, slot_id_o == '0, "flagged result carries an id")
  `SPADS_ASSERT_NOW(a_top_floor, out_valid_o && top_index_o[CNT_W-1], top_index_o == top_t'(-1), "top index below minus one")

endmodule

bind slot_pool_alive_dead_stacks spads_checker u_spads_checker (.*);
